/* sv/xs_pkg.sv */
// Package for the xoshiro256** generator with splitmix64 seeding.
// Holds the transfer payload types, command codes and constants shared by all modules but the queue.
// No dependencies.
package xs_pkg;

    localparam logic [1:0] FUNC_SEED_MIX   = 2'd0;
    localparam logic [1:0] FUNC_SEED_WORDS = 2'd1;
    localparam logic [1:0] FUNC_DRAW       = 2'd2;
    localparam logic [1:0] FUNC_ONE_SHOT   = 2'd3;

    localparam logic [1:0] FMT_RAW   = 2'd0;
    localparam logic [1:0] FMT_LOW31 = 2'd1;
    localparam logic [1:0] FMT_LOW32 = 2'd2;
    localparam logic [1:0] FMT_TOP53 = 2'd3;

    localparam logic [63:0] GOLDEN_INC  = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MIX_MUL_A   = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MIX_MUL_B   = 64'h94D049BB133111EB;
    localparam logic [63:0] FOURTH_WORD = 64'h00000000DEADBEEF;
    localparam logic [63:0] MASK31      = 64'h000000007FFFFFFF;
    localparam logic [63:0] MASK32      = 64'h00000000FFFFFFFF;

    typedef enum logic [1:0] {
        OP_SEED_MIX,
        OP_SEED_WORDS,
        OP_DRAW,
        OP_ONE_SHOT
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL_A,
        ST_MUL_B,
        ST_DRAW_OUT
    } t_back_state;

    typedef struct packed {
        logic [1:0]  func;
        logic [63:0] seed_value;
        logic [47:0] short_words;
        logic [1:0]  out_format;
    } t_in_item;

    typedef struct packed {
        logic [63:0] raw_value;
        logic [63:0] shaped_value;
    } t_out_item;

    typedef struct packed {
        t_op         op;
        logic        needs_result;
        logic [63:0] seed_value;
        logic [47:0] short_words;
        logic [1:0]  out_format;
    } t_cmd;

    typedef logic [3:0][63:0] t_words;

endpackage

/* sv/xs_fifo.sv */
// Small synchronous queue of registers with count-based full and empty flags.
// Used for the command queue and the result queue. No package dependency.
module xs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, n_wr;
    logic [PW-1:0]    r_rd, n_rd;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push;
    logic             do_pop;

    function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
        if (p == PW'(DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_wr    = do_push ? next_ptr(r_wr) : r_wr;
        n_rd    = do_pop ? next_ptr(r_rd) : r_rd;
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

/* sv/xs_front.sv */
// Front stage: takes input transfers, classifies the command and registers it.
// Depends on xs_pkg; feeds the command queue.
module xs_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  xs_pkg::t_in_item i_item,
    output logic            o_full,
    output logic            o_cmd_valid,
    output xs_pkg::t_cmd    o_cmd,
    input  logic            i_queue_full
);

    logic         r_valid, n_valid;
    xs_pkg::t_cmd r_cmd, n_cmd;
    logic         accept;
    logic         drain;

    assign drain       = r_valid && !i_queue_full;
    assign o_full      = r_valid && i_queue_full;
    assign accept      = i_push && !o_full;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    always_comb begin
        n_valid = accept || (r_valid && !drain);
        n_cmd   = r_cmd;
        if (accept) begin
            n_cmd.seed_value  = i_item.seed_value;
            n_cmd.short_words = i_item.short_words;
            n_cmd.out_format  = i_item.out_format;
            case (i_item.func)
                xs_pkg::FUNC_SEED_MIX: begin
                    n_cmd.op           = xs_pkg::OP_SEED_MIX;
                    n_cmd.needs_result = 1'b0;
                end
                xs_pkg::FUNC_SEED_WORDS: begin
                    n_cmd.op           = xs_pkg::OP_SEED_WORDS;
                    n_cmd.needs_result = 1'b0;
                end
                xs_pkg::FUNC_DRAW: begin
                    n_cmd.op           = xs_pkg::OP_DRAW;
                    n_cmd.needs_result = 1'b1;
                end
                default: begin
                    n_cmd.op           = xs_pkg::OP_ONE_SHOT;
                    n_cmd.needs_result = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
    end

endmodule

/* sv/xs_back.sv */
// Back end: holds the generator state and carries out queued commands.
// Seed-mix seeding runs splitmix64 on one shared 32x32 multiplier; depends on xs_pkg.
module xs_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_empty,
    input  xs_pkg::t_cmd      i_cmd,
    output logic              o_cmd_pop,
    input  logic              i_res_full,
    output logic              o_res_push,
    output xs_pkg::t_out_item o_res
);

    localparam logic [1:0] PHASE_POST = 2'd3;
    localparam logic [1:0] PHASE_HIGH = 2'd2;
    localparam logic [1:0] PHASE_MID  = 2'd1;
    localparam logic [1:0] PHASE_LOW  = 2'd0;
    localparam logic [1:0] LAST_WORD  = 2'd3;

    xs_pkg::t_back_state r_state, n_state;
    xs_pkg::t_words      r_words, n_words;
    logic [63:0]         r_acc, n_acc;
    logic [63:0]         r_z, n_z;
    logic [63:0]         r_prod, n_prod;
    logic [1:0]          r_phase, n_phase;
    logic [1:0]          r_idx, n_idx;
    logic [63:0]         r_m5, n_m5;
    logic [1:0]          r_fmt, n_fmt;

    logic                cmd_take;
    xs_pkg::t_words      short_load;
    logic [63:0]         mul_k;
    logic [31:0]         mul_a;
    logic [31:0]         mul_b;
    logic [63:0]         mul_p;
    logic [63:0]         rot;
    logic [63:0]         raw;

    function automatic xs_pkg::t_words advance(input xs_pkg::t_words w);
        xs_pkg::t_words v;
        logic [63:0]    w3x;
        w3x  = w[3] ^ w[1];
        v[0] = w[0] ^ w3x;
        v[1] = w[1] ^ w[2] ^ w[0];
        v[2] = w[2] ^ w[0] ^ {w[1][46:0], 17'b0};
        v[3] = {w3x[18:0], w3x[63:19]};
        return v;
    endfunction

    function automatic logic [63:0] shape(input logic [63:0] v, input logic [1:0] fmt);
        case (fmt)
            xs_pkg::FMT_LOW31: return v & xs_pkg::MASK31;
            xs_pkg::FMT_LOW32: return v & xs_pkg::MASK32;
            xs_pkg::FMT_TOP53: return v >> 11;
            default:           return v;
        endcase
    endfunction

    assign cmd_take = (r_state == xs_pkg::ST_IDLE) && !i_cmd_empty
                      && (!i_cmd.needs_result || !i_res_full);
    assign o_cmd_pop = cmd_take;

    assign short_load[0] = {48'b0, i_cmd.short_words[15:0]};
    assign short_load[1] = {48'b0, i_cmd.short_words[31:16]};
    assign short_load[2] = {48'b0, i_cmd.short_words[47:32]};
    assign short_load[3] = xs_pkg::FOURTH_WORD;

    assign mul_k = (r_state == xs_pkg::ST_MUL_A) ? xs_pkg::MIX_MUL_A : xs_pkg::MIX_MUL_B;
    assign mul_a = (r_phase == PHASE_HIGH) ? r_z[63:32] : r_z[31:0];
    assign mul_b = (r_phase == PHASE_MID) ? mul_k[63:32] : mul_k[31:0];
    assign mul_p = 64'(mul_a) * 64'(mul_b);

    assign rot                = {r_m5[56:0], r_m5[63:57]};
    assign raw                = rot + {rot[60:0], 3'b0};
    assign o_res.raw_value    = raw;
    assign o_res.shaped_value = shape(raw, r_fmt);

    always_comb begin
        n_state = r_state;
        case (r_state)
            xs_pkg::ST_IDLE: begin
                if (cmd_take) begin
                    case (i_cmd.op)
                        xs_pkg::OP_SEED_MIX:   n_state = xs_pkg::ST_MUL_A;
                        xs_pkg::OP_SEED_WORDS: n_state = xs_pkg::ST_IDLE;
                        default:               n_state = xs_pkg::ST_DRAW_OUT;
                    endcase
                end
            end
            xs_pkg::ST_MUL_A: begin
                if (r_phase == PHASE_POST) begin
                    n_state = xs_pkg::ST_MUL_B;
                end
            end
            xs_pkg::ST_MUL_B: begin
                if (r_phase == PHASE_POST) begin
                    n_state = (r_idx == LAST_WORD) ? xs_pkg::ST_IDLE : xs_pkg::ST_MUL_A;
                end
            end
            default: n_state = xs_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        logic [63:0] acc_sum;
        n_words    = r_words;
        n_acc      = r_acc;
        n_z        = r_z;
        n_prod     = r_prod;
        n_phase    = r_phase;
        n_idx      = r_idx;
        n_m5       = r_m5;
        n_fmt      = r_fmt;
        o_res_push = 1'b0;
        acc_sum    = r_acc + xs_pkg::GOLDEN_INC;
        case (r_state)
            xs_pkg::ST_IDLE: begin
                if (cmd_take) begin
                    n_fmt = i_cmd.out_format;
                    case (i_cmd.op)
                        xs_pkg::OP_SEED_MIX: begin
                            acc_sum = i_cmd.seed_value + xs_pkg::GOLDEN_INC;
                            n_acc   = acc_sum;
                            n_z     = acc_sum ^ (acc_sum >> 30);
                            n_phase = PHASE_LOW;
                            n_idx   = '0;
                        end
                        xs_pkg::OP_SEED_WORDS: begin
                            n_words = short_load;
                        end
                        xs_pkg::OP_DRAW: begin
                            n_m5    = r_words[1] + {r_words[1][61:0], 2'b0};
                            n_words = advance(r_words);
                        end
                        default: begin
                            n_m5 = short_load[1] + {short_load[1][61:0], 2'b0};
                        end
                    endcase
                end
            end
            xs_pkg::ST_MUL_A, xs_pkg::ST_MUL_B: begin
                if (r_phase == PHASE_LOW) begin
                    n_prod  = mul_p;
                    n_phase = r_phase + 1'b1;
                end else if (r_phase != PHASE_POST) begin
                    n_prod  = {r_prod[63:32] + mul_p[31:0], r_prod[31:0]};
                    n_phase = r_phase + 1'b1;
                end else begin
                    n_phase = PHASE_LOW;
                    if (r_state == xs_pkg::ST_MUL_A) begin
                        n_z = r_prod ^ (r_prod >> 27);
                    end else begin
                        n_words[r_idx] = r_prod ^ (r_prod >> 31);
                        n_acc          = acc_sum;
                        n_z            = acc_sum ^ (acc_sum >> 30);
                        n_idx          = r_idx + 1'b1;
                    end
                end
            end
            default: begin
                o_res_push = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= xs_pkg::ST_IDLE;
            r_words <= '0;
            r_phase <= PHASE_LOW;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_words <= n_words;
            r_phase <= n_phase;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc  <= n_acc;
        r_z    <= n_z;
        r_prod <= n_prod;
        r_m5   <= n_m5;
        r_fmt  <= n_fmt;
    end

endmodule

/* sv/xoshiro256ss_generator.sv */
// xoshiro256** generator with splitmix64 seeding, four 64-bit state words in registers.
// A front stage classifies commands into a short command queue; the back end executes them
// and places draw results in a result queue. Seed-words loads the state directly; a draw
// mixes output and takes a multiply-free state step, a one-shot draw only mixes its own words;
// seed-mix is paced by the shared 32x32 multiplier that forms each 64-bit splitmix64 product
// from three partial products plus a mixing step, twice for each of the four words. A result
// passes the front stage register, the command queue and the back end before the result queue. State is zero after
// reset, and a draw from an unseeded state returns zero.
module xoshiro256ss_generator #(
    parameter int CMD_DEPTH = 2,
    parameter int RES_DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  xs_pkg::t_in_item  i_item,
    output logic              empty,
    input  logic              pop,
    output xs_pkg::t_out_item o_result
);

    localparam int CMD_W = $bits(xs_pkg::t_cmd);
    localparam int RES_W = $bits(xs_pkg::t_out_item);

    logic              front_valid;
    xs_pkg::t_cmd      front_cmd;
    logic              cmdq_full;
    logic              cmdq_empty;
    logic [CMD_W-1:0]  cmdq_data;
    xs_pkg::t_cmd      back_cmd;
    logic              back_pop;
    logic              resq_full;
    logic              back_push;
    xs_pkg::t_out_item back_res;
    logic [RES_W-1:0]  resq_data;

    xs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_item),
        .o_full      (full),
        .o_cmd_valid (front_valid),
        .o_cmd       (front_cmd),
        .i_queue_full(cmdq_full)
    );

    xs_fifo #(.WIDTH(CMD_W), .DEPTH(CMD_DEPTH)) u_cmd_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (front_valid),
        .i_data (front_cmd),
        .o_full (cmdq_full),
        .i_pop  (back_pop),
        .o_data (cmdq_data),
        .o_empty(cmdq_empty)
    );

    assign back_cmd = cmdq_data;

    xs_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_empty(cmdq_empty),
        .i_cmd      (back_cmd),
        .o_cmd_pop  (back_pop),
        .i_res_full (resq_full),
        .o_res_push (back_push),
        .o_res      (back_res)
    );

    xs_fifo #(.WIDTH(RES_W), .DEPTH(RES_DEPTH)) u_res_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (back_push),
        .i_data (back_res),
        .o_full (resq_full),
        .i_pop  (pop),
        .o_data (resq_data),
        .o_empty(empty)
    );

    assign o_result = resq_data;

endmodule

/* sv/xs_checker.sv */
// Port-level checker for the xoshiro256** generator, attached to the top level by bind.
// Depends on xs_pkg and the top-level ports of xoshiro256ss_generator.
module xs_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              push,
    input logic              full,
    input xs_pkg::t_in_item  i_item,
    input logic              empty,
    input logic              pop,
    input xs_pkg::t_out_item o_result
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not cleared by reset");

    a_input_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && full |=> push && $stable(i_item))
        else $error("offered input changed before its transfer");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_result))
        else $error("waiting result changed before its transfer");

    a_shape_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_result.shaped_value == o_result.raw_value)
            || (o_result.shaped_value == (o_result.raw_value & xs_pkg::MASK31))
            || (o_result.shaped_value == (o_result.raw_value & xs_pkg::MASK32))
            || (o_result.shaped_value == (o_result.raw_value >> 11)))
        else $error("shaped value does not match any format");

    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(empty) |-> $past(i_rst_n, 1) && $past(i_rst_n, 2) && $past(i_rst_n, 3))
        else $error("result appeared too soon after reset");

endmodule

bind xoshiro256ss_generator xs_checker u_checker (.*);

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the xoshiro256** generator with splitmix64 seeding.
// A scoreboard class predicts every draw, keeping its own copy of the four state words.
// Depends on xs_pkg and xoshiro256ss_generator.
module testbench;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int PHASE_ITEMS    = 225;
    localparam int HOLD_CYCLES    = 200;

    class xoshiro_scoreboard;
        xs_pkg::t_words    gen_state;
        xs_pkg::t_out_item expected_draws[$];
        int                errors;

        function new();
            gen_state = '0;
            errors    = 0;
        endfunction

        function logic [63:0] splitmix_next(inout logic [63:0] acc);
            logic [63:0] z;
            acc = acc + xs_pkg::GOLDEN_INC;
            z = acc;
            z = (z ^ (z >> 30)) * xs_pkg::MIX_MUL_A;
            z = (z ^ (z >> 27)) * xs_pkg::MIX_MUL_B;
            return z ^ (z >> 31);
        endfunction

        function logic [63:0] xoshiro_step(inout xs_pkg::t_words w);
            logic [63:0] prod;
            logic [63:0] result;
            logic [63:0] t;
            prod   = w[1] * 64'd5;
            result = {prod[56:0], prod[63:57]} * 64'd9;
            t      = w[1] << 17;
            w[2]   = w[2] ^ w[0];
            w[3]   = w[3] ^ w[1];
            w[1]   = w[1] ^ w[2];
            w[0]   = w[0] ^ w[3];
            w[2]   = w[2] ^ t;
            w[3]   = {w[3][18:0], w[3][63:19]};
            return result;
        endfunction

        function xs_pkg::t_words words_from_short(logic [47:0] packed_words);
            xs_pkg::t_words w;
            w[0] = {48'd0, packed_words[15:0]};
            w[1] = {48'd0, packed_words[31:16]};
            w[2] = {48'd0, packed_words[47:32]};
            w[3] = xs_pkg::FOURTH_WORD;
            return w;
        endfunction

        function logic [63:0] shaped(logic [63:0] v, logic [1:0] fmt);
            case (fmt)
                xs_pkg::FMT_LOW31: return v & xs_pkg::MASK31;
                xs_pkg::FMT_LOW32: return v & xs_pkg::MASK32;
                xs_pkg::FMT_TOP53: return v >> 11;
                default:           return v;
            endcase
        endfunction

        function void note_command(xs_pkg::t_in_item it);
            logic [63:0]       acc;
            xs_pkg::t_words    scratch;
            xs_pkg::t_out_item draw;
            draw = '0;
            case (it.func)
                xs_pkg::FUNC_SEED_MIX: begin
                    acc = it.seed_value;
                    for (int i = 0; i < 4; i++) gen_state[i] = splitmix_next(acc);
                    return;
                end
                xs_pkg::FUNC_SEED_WORDS: begin
                    gen_state = words_from_short(it.short_words);
                    return;
                end
                xs_pkg::FUNC_DRAW: begin
                    draw.raw_value = xoshiro_step(gen_state);
                end
                default: begin
                    scratch = words_from_short(it.short_words);
                    draw.raw_value = xoshiro_step(scratch);
                end
            endcase
            draw.shaped_value = shaped(draw.raw_value, it.out_format);
            expected_draws.push_back(draw);
        endfunction

        function void check_draw(xs_pkg::t_out_item got);
            xs_pkg::t_out_item want;
            if (expected_draws.size() == 0) begin
                $display("%0t: result transfer with none expected: raw %h, shaped %h",
                         $time, got.raw_value, got.shaped_value);
                errors++;
                return;
            end
            want = expected_draws.pop_front();
            if (got.raw_value !== want.raw_value) begin
                $display("%0t: raw_value mismatch: expected %h, actual %h",
                         $time, want.raw_value, got.raw_value);
                errors++;
            end
            if (got.shaped_value !== want.shaped_value) begin
                $display("%0t: shaped_value mismatch: expected %h, actual %h",
                         $time, want.shaped_value, got.shaped_value);
                errors++;
            end
        endfunction

        function int pending();
            return expected_draws.size();
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              push;
    logic              full;
    xs_pkg::t_in_item  i_item;
    logic              empty;
    logic              pop;
    xs_pkg::t_out_item o_result;

    xoshiro_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_req = 0;
    int hold_seen;
    int hold_left;
    int idle_cycles = 0;

    xoshiro256ss_generator u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_item  (i_item),
        .empty   (empty),
        .pop     (pop),
        .o_result(o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full) sb.note_command(i_item);
            if (pop && !empty) sb.check_draw(o_result);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((push && !full) || (pop && !empty)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        pop       = 1'b0;
        hold_seen = 0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic send_item(input xs_pkg::t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            push <= 1'b0;
        end
        @(negedge i_clk);
        push   <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
    endtask

    task automatic send_fields(input logic [1:0] func, input logic [63:0] seed,
                               input logic [47:0] words, input logic [1:0] fmt);
        xs_pkg::t_in_item it;
        it.func        = func;
        it.seed_value  = seed;
        it.short_words = words;
        it.out_format  = fmt;
        send_item(it);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        push <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic xs_pkg::t_in_item random_item();
        xs_pkg::t_in_item it;
        int               pick;
        it.seed_value  = {$urandom, $urandom};
        it.short_words = {16'($urandom), 32'($urandom)};
        it.out_format  = 2'($urandom);
        pick = $urandom_range(99);
        if (pick < 6) begin
            it.func = xs_pkg::FUNC_SEED_MIX;
            if ($urandom_range(2) == 0) it.seed_value[63:32] = '0;
        end else if (pick < 14) begin
            it.func = xs_pkg::FUNC_SEED_WORDS;
        end else if (pick < 30) begin
            it.func = xs_pkg::FUNC_ONE_SHOT;
        end else begin
            it.func = xs_pkg::FUNC_DRAW;
        end
        return it;
    endfunction

    initial begin
        sb             = new();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        i_rst_n        = 1'b0;
        push           = 1'b0;
        i_item         = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Unseeded draws return zero and keep the state zero; seeding and draws follow.
        send_fields(xs_pkg::FUNC_DRAW, '1, '1, xs_pkg::FMT_RAW);
        send_fields(xs_pkg::FUNC_DRAW, '0, '0, xs_pkg::FMT_TOP53);
        send_fields(xs_pkg::FUNC_ONE_SHOT, '0, '0, xs_pkg::FMT_RAW);
        send_fields(xs_pkg::FUNC_ONE_SHOT, '0, '1, xs_pkg::FMT_TOP53);
        send_fields(xs_pkg::FUNC_SEED_WORDS, '1, '0, xs_pkg::FMT_RAW);
        send_fields(xs_pkg::FUNC_DRAW, '0, '0, xs_pkg::FMT_LOW31);
        send_fields(xs_pkg::FUNC_SEED_WORDS, '0, '1, xs_pkg::FMT_RAW);
        send_fields(xs_pkg::FUNC_DRAW, '0, '0, xs_pkg::FMT_LOW32);
        send_fields(xs_pkg::FUNC_DRAW, '0, '0, xs_pkg::FMT_TOP53);
        send_fields(xs_pkg::FUNC_DRAW, '0, '0, xs_pkg::FMT_RAW);
        send_fields(xs_pkg::FUNC_SEED_MIX, '0, '0, xs_pkg::FMT_RAW);
        send_fields(xs_pkg::FUNC_DRAW, '0, '0, xs_pkg::FMT_RAW);
        send_fields(xs_pkg::FUNC_DRAW, '0, '0, xs_pkg::FMT_LOW31);
        send_fields(xs_pkg::FUNC_SEED_MIX, '1, '1, xs_pkg::FMT_TOP53);
        send_fields(xs_pkg::FUNC_DRAW, '0, '0, xs_pkg::FMT_TOP53);
        send_fields(xs_pkg::FUNC_DRAW, '0, '0, xs_pkg::FMT_LOW32);
        send_fields(xs_pkg::FUNC_SEED_MIX, 64'h00000000FFFFFFFF, '0, xs_pkg::FMT_RAW);
        send_fields(xs_pkg::FUNC_DRAW, '0, '0, xs_pkg::FMT_RAW);
        // A one-shot draw in between must not disturb the running state.
        send_fields(xs_pkg::FUNC_ONE_SHOT, '0, 48'h123456789ABC, xs_pkg::FMT_LOW32);
        send_fields(xs_pkg::FUNC_DRAW, '0, '0, xs_pkg::FMT_RAW);
        wait_drained();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 76; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 76; end
                default: begin send_idle_pct = 25; recv_stall_pct = 25; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // The receiver holds off while commands keep coming, so the queues fill up.
                if (phase == 0 && n == 60) hold_req++;
                send_item(random_item());
            end
            wait_drained();
        end

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
